// ----- rtl/core/tepq_pkg.sv -----
package tepq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_SQUASH  = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_PLACE,
    FSM_HEAD,
    FSM_RESULT
  } fsm_t;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned ThreadCount = 8;
  localparam int unsigned ThreadW     = $clog2(ThreadCount);

  typedef struct packed {
    logic [KeyW-1:0]    done_time;
    logic [KeyW-1:0]    op_id;
    logic [ThreadW-1:0] thread;
    logic               speculative;
    logic               is_load;
    logic [KeyW-1:0]    issue_cycle;
  } entry_t;

  localparam logic [7:0] LongLatencyReset = 8'd20;
  localparam logic [7:0] MissReset        = 8'd5;
  localparam logic       RegLongLatency   = 1'b0;
  localparam logic       RegMiss          = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch command, clear scan state
    logic scan;       // read/compare step over entries
    logic shift;      // one move step
    logic place;      // write new entry
    logic head;       // capture head entry
    logic finish;     // update count, build result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic shift_last;
    logic is_full;
    logic is_empty;
  } sts_t;

endpackage

// ----- rtl/core/tepq_if.sv -----
interface tepq_in_if;
  import tepq_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        done_time;
  logic [31:0]        op_id;
  logic [2:0]         thread_sel;
  logic               speculative;
  logic               is_load;
  logic [31:0]        issue_cycle;
  logic [31:0]        now_cycle;
  modport source (output valid, command, done_time, op_id, thread_sel, speculative,
                  is_load, issue_cycle, now_cycle, input ready);
  modport sink (input valid, command, done_time, op_id, thread_sel, speculative,
                is_load, issue_cycle, now_cycle, output ready);
endinterface

interface tepq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_done_time;
  logic [31:0] out_op_id;
  logic [2:0]  out_thread;
  logic        out_speculative;
  logic        out_is_load;
  logic [31:0] out_issue_cycle;
  logic        long_latency;
  logic        load_miss;
  logic [6:0]  occupancy;
  modport source (output valid, status, out_done_time, out_op_id, out_thread,
                  out_speculative, out_is_load, out_issue_cycle, long_latency,
                  load_miss, occupancy, input ready);
  modport sink (input valid, status, out_done_time, out_op_id, out_thread,
                out_speculative, out_is_load, out_issue_cycle, long_latency,
                load_miss, occupancy, output ready);
endinterface

// ----- rtl/core/tepq_ctrl.sv -----
module tepq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_command,
  output logic           res_load,
  input  logic           res_free,
  output tepq_pkg::ctl_t ctl,
  input  tepq_pkg::sts_t sts
);
  import tepq_pkg::*;

  fsm_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      cmd_r   <= CMD_INSERT;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          cmd_nxt = cmd_t'(in_command);
          case (cmd_t'(in_command))
            CMD_INSERT:  state_nxt = FSM_SCAN;
            CMD_EXTRACT: state_nxt = FSM_HEAD;
            CMD_SQUASH:  state_nxt = FSM_SHIFT;
            CMD_QUERY:   state_nxt = FSM_SCAN;
            default:     state_nxt = FSM_SCAN;
          endcase
        end
      end
      FSM_SCAN: begin
        if (sts.scan_last) begin
          if (cmd_r == CMD_INSERT && !sts.is_full) state_nxt = FSM_SHIFT;
          else state_nxt = FSM_RESULT;
        end
      end
      FSM_SHIFT: begin
        if (sts.shift_last) begin
          if (cmd_r == CMD_INSERT) state_nxt = FSM_PLACE;
          else state_nxt = FSM_RESULT;
        end
      end
      FSM_PLACE: state_nxt = FSM_RESULT;
      FSM_HEAD: begin
        if (sts.is_empty) state_nxt = FSM_RESULT;
        else state_nxt = FSM_SHIFT;
      end
      FSM_RESULT: begin
        if (res_free) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_ready  = 1'b1;
        ctl.start = in_valid;
      end
      FSM_SCAN:  ctl.scan  = 1'b1;
      FSM_SHIFT: ctl.shift = 1'b1;
      FSM_PLACE: ctl.place = 1'b1;
      FSM_HEAD:  ctl.head  = 1'b1;
      FSM_RESULT: begin
        ctl.finish = res_free;
        res_load   = res_free;
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == FSM_IDLE) else $error("ready outside idle");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> state_r == FSM_IDLE) else $error("result not followed by idle");
  a_place_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_PLACE |-> $past(state_r) == FSM_SHIFT) else $error("place order");
endmodule

// ----- rtl/core/tepq_dp.sv -----
module tepq_dp #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned CntW = 7,
  parameter int unsigned IdxW = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tepq_pkg::ctl_t ctl,
  output tepq_pkg::sts_t sts,
  input  logic [1:0]     in_command,
  input  tepq_pkg::entry_t in_entry,
  input  logic [31:0]    in_now,
  input  logic [7:0]     long_limit,
  input  logic [7:0]     miss_limit,
  output logic [1:0]     res_status,
  output tepq_pkg::entry_t res_entry,
  output logic           res_long,
  output logic           res_miss,
  output logic [CntW-1:0] res_count
);
  import tepq_pkg::*;

  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];

  logic [CntW-1:0] count_r;
  cmd_t            cmd_r;
  entry_t          new_r;
  logic [31:0]     now_r;
  logic [CntW-1:0] pos_r;    // scan index / insert position
  logic            found_r;
  logic [CntW-1:0] rd_r;     // shift read pointer
  logic [CntW-1:0] wr_r;     // shift write pointer
  logic            rdv_r;    // read data valid in pipe
  logic [CntW-1:0] rdi_r;    // index of registered read data
  entry_t          rdd_r;
  entry_t          head_r;
  logic            long_r, miss_r;
  logic [1:0]      status_r;

  // one registered read port, one write port
  logic [IdxW-1:0] ra;
  logic            we;
  logic [IdxW-1:0] wa;
  entry_t          wd;

  logic [CntW-1:0] rd_end;
  logic            cmp_before, match, drop;
  logic [31:0]     age;

  always_comb begin
    cmp_before = (new_r.done_time != rdd_r.done_time) ?
                 (new_r.done_time < rdd_r.done_time) : (new_r.op_id < rdd_r.op_id);
    match = rdd_r.thread == new_r.thread;
    drop  = match && rdd_r.speculative;
    age   = now_r - rdd_r.issue_cycle;
  end

  // reads issued up to rd_end, the issued pointer is rd_r
  always_comb begin
    rd_end = count_r;
    ra = rd_r[IdxW-1:0];
    we = 1'b0;
    wa = wr_r[IdxW-1:0];
    wd = rdd_r;
    if (ctl.shift) begin
      case (cmd_r)
        CMD_INSERT: begin
          // move downward: read slot rd-1, write slot rd
          ra = IdxW'(rd_r - CntW'(1));
          we = rdv_r;
          wa = rdi_r[IdxW-1:0] + IdxW'(1);
        end
        default: begin
          we = rdv_r && !(cmd_r == CMD_SQUASH && drop);
        end
      endcase
    end else if (ctl.place) begin
      we = 1'b1;
      wa = pos_r[IdxW-1:0];
      wd = new_r;
    end else if (ctl.head) begin
      ra = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdd_r <= mem[ra];
  end

  always_comb begin
    sts.is_full  = count_r >= DepthC;
    sts.is_empty = count_r == '0;
    sts.scan_last  = rdv_r && (rd_r >= rd_end || (cmd_r == CMD_INSERT && cmp_before))
                     || (!rdv_r && rd_r >= rd_end)
                     || (cmd_r == CMD_INSERT && count_r >= DepthC);
    if (cmd_r == CMD_INSERT)
      sts.shift_last = rd_r <= pos_r && !rdv_r;
    else
      sts.shift_last = rd_r >= rd_end && !rdv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rdv_r   <= 1'b0;
      rd_r    <= '0;
      wr_r    <= '0;
    end else if (ctl.start) begin
      cmd_r    <= cmd_t'(in_command);
      new_r    <= in_entry;
      now_r    <= in_now;
      rd_r     <= '0;
      wr_r     <= '0;
      rdv_r    <= 1'b0;
      pos_r    <= '0;
      found_r  <= 1'b0;
      long_r   <= 1'b0;
      miss_r   <= 1'b0;
      status_r <= ST_DONE;
      head_r   <= '0;
    end else if (ctl.scan) begin
      if (rdv_r) begin
        if (cmd_r == CMD_INSERT) begin
          if (!found_r && !cmp_before) pos_r <= rdi_r + CntW'(1);
          if (cmp_before) found_r <= 1'b1;
        end else if (match) begin
          if (age > {24'd0, long_limit}) long_r <= 1'b1;
          if (rdd_r.is_load && age > {24'd0, miss_limit}) miss_r <= 1'b1;
        end
      end
      if (cmd_r == CMD_INSERT && count_r >= DepthC) status_r <= ST_FULL;
      if (sts.scan_last) begin
        rdv_r <= 1'b0;
        rd_r  <= count_r;   // insert shift starts at the tail
      end else if (rd_r < rd_end) begin
        rdv_r <= 1'b1;
        rdi_r <= rd_r;
        rd_r  <= rd_r + CntW'(1);
      end else begin
        rdv_r <= 1'b0;
      end
    end else if (ctl.shift) begin
      if (we && cmd_r != CMD_INSERT) wr_r <= wr_r + CntW'(1);
      if (cmd_r == CMD_INSERT) begin
        if (rd_r > pos_r) begin
          rdv_r <= 1'b1;
          rdi_r <= rd_r - CntW'(1);
          rd_r  <= rd_r - CntW'(1);
        end else begin
          rdv_r <= 1'b0;
        end
      end else if (rd_r < rd_end) begin
        rdv_r <= 1'b1;
        rdi_r <= rd_r;
        rd_r  <= rd_r + CntW'(1);
      end else begin
        rdv_r <= 1'b0;
      end
    end else if (ctl.head) begin
      if (count_r == '0) status_r <= ST_EMPTY;
      rd_r <= CntW'(1);
      rdv_r <= 1'b0;
    end else if (ctl.finish) begin
      case (cmd_r)
        CMD_INSERT:  if (status_r == ST_DONE) count_r <= count_r + CntW'(1);
        CMD_EXTRACT: if (status_r == ST_DONE) count_r <= count_r - CntW'(1);
        CMD_SQUASH:  count_r <= wr_r;
        default: ;
      endcase
    end
    // head capture: read data of slot 0 arrives in the cycle after the head state
    if (rst_n && ctl.shift && cmd_r == CMD_EXTRACT && rd_r == CntW'(1) && !rdv_r)
      head_r <= rdd_r;
  end

  // extract: shift pass starts with rd=1, wr=0; first cycle sees slot 0 data
  always_comb begin
    res_status = status_r;
    res_entry  = head_r;
    res_long   = long_r;
    res_miss   = miss_r;
    case (cmd_r)
      CMD_INSERT:  res_count = (status_r == ST_DONE) ? count_r + CntW'(1) : count_r;
      CMD_EXTRACT: res_count = (status_r == ST_DONE) ? count_r - CntW'(1) : count_r;
      CMD_SQUASH:  res_count = wr_r;
      default:     res_count = count_r;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthC) else $error("count overflow");
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift && cmd_r == CMD_SQUASH) |-> wr_r <= rd_r) else $error("squash pointers");
  a_full_no_place: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.place |-> !sts.is_full) else $error("place into full queue");
endmodule

// ----- rtl/core/timed_event_priority_queue_squash.sv -----
// Completion-event queue, sorted by done time then op id.
// in channel: one command item (insert, extract, squash, query) accepted
// when in_valid and in_ready; ready is high only while the block is idle.
// out channel: exactly one result item per command, held in an output
// register until out_ready; the next command is taken once the result
// has moved into that register.
// Steps per item, with one memory read port:
//   insert  scan for the position, shift the tail up, place
//   extract head read, then shift down
//   squash  one compacting pass
//   query   one scan
// An insert into a full queue is rejected after its scan, with no shift
// and no place.
// cfg port: APB-style writes to long_latency_limit (0x0) and miss_limit
// (0x4), taken at any time, meant for idle periods; reads return them.
// Reset: occupancy returns to zero and the limits to 20 and 5; the entry
// memory needs no clearing. A stalled receiver holds its result; the block
// then waits in its result step with in_ready low until the register frees.
module timed_event_priority_queue_squash #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tepq_in_if.sink     in_ch,
  tepq_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tepq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  ctl_t ctl;
  sts_t sts;
  logic res_load, res_free;
  logic [7:0] long_r, miss_r;
  logic out_valid_r;
  entry_t in_entry, res_entry;
  logic [1:0] res_status;
  logic res_long, res_miss;
  logic [CntW-1:0] res_count;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r <= LongLatencyReset;
      miss_r <= MissReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == RegLongLatency) long_r <= cfg_pwdata[7:0];
      else miss_r <= cfg_pwdata[7:0];
    end
  end
  assign cfg_prdata = {24'd0, (cfg_paddr[2] == RegLongLatency) ? long_r : miss_r};

  assign in_entry = '{done_time: in_ch.done_time, op_id: in_ch.op_id,
                      thread: in_ch.thread_sel, speculative: in_ch.speculative,
                      is_load: in_ch.is_load, issue_cycle: in_ch.issue_cycle};

  assign res_free = !out_valid_r || out_ch.ready;

  tepq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
    .res_load, .res_free, .ctl, .sts
  );

  tepq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .CntW(CntW), .IdxW(IdxW)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_command(in_ch.command), .in_entry, .in_now(in_ch.now_cycle),
    .long_limit(long_r), .miss_limit(miss_r),
    .res_status, .res_entry, .res_long, .res_miss, .res_count
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      out_ch.status          <= res_status;
      out_ch.out_done_time   <= res_entry.done_time;
      out_ch.out_op_id       <= res_entry.op_id;
      out_ch.out_thread      <= res_entry.thread;
      out_ch.out_speculative <= res_entry.speculative;
      out_ch.out_is_load     <= res_entry.is_load;
      out_ch.out_issue_cycle <= res_entry.issue_cycle;
      out_ch.long_latency    <= res_long;
      out_ch.load_miss       <= res_miss;
      out_ch.occupancy       <= 7'(res_count);
    end
  end
  assign out_ch.valid = out_valid_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result lost");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("double accept");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_ch.occupancy))
    else $error("result changed while stalled");
endmodule
